[rtl/line_gap_buffer_defines.svh]
// assertion macros for the line gap buffer
`ifndef LINE_GAP_BUFFER_DEFINES_SVH
`define LINE_GAP_BUFFER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LGB_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LGB_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[rtl/lgb_pkg.sv]
// types and codes shared by the line gap buffer
`default_nettype none

package lgb_pkg;

  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 9;
  localparam int ENTRY_PORT_W = 32;

  typedef enum logic [MODE_W-1:0] {
    M_INSERT = 3'd0,
    M_DELETE = 3'd1,
    M_LEFT   = 3'd2,
    M_RIGHT  = 3'd3,
    M_SEEK   = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_START = 3'd1,
    ST_END   = 3'd2,
    ST_FULL  = 3'd3,
    ST_BAD   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SWAP_RD = 4'b0010,
    S_SWAP_WR = 4'b0100,
    S_FETCH   = 4'b1000
  } state_t;

endpackage

`default_nettype wire

[rtl/line_gap_buffer.sv]
// line gap buffer top level: command sequencer around the line store
//
//   channel  handshake             fields
//   cmd      cmd_valid/cmd_stall   mode, entry_value, line_number
//   res      res_valid/res_stall   status, read_entry, gap_position, line_total
//
// insert, delete, unknown modes and all errors give a result in the cycle after acceptance
// gap left and gap right do one ram read and one ram write for the swap
// seek does k swaps (k up to DEPTH) and a line read, bound by the single read port
// reset clears the gap counters, state and result valid; the store holds no valid bits and needs no clearing
// a held result stalls new commands; a command in progress stalls the next one
`default_nettype none
`include "line_gap_buffer_defines.svh"

module line_gap_buffer #(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_stall,
  input  wire logic [lgb_pkg::MODE_W-1:0]         mode,
  input  wire logic [lgb_pkg::ENTRY_PORT_W-1:0]   entry_value,
  input  wire logic [lgb_pkg::COUNT_W-1:0]        line_number,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output logic      [lgb_pkg::STATUS_W-1:0]       status,
  output logic      [lgb_pkg::ENTRY_PORT_W-1:0]   read_entry,
  output logic      [lgb_pkg::COUNT_W-1:0]        gap_position,
  output logic      [lgb_pkg::COUNT_W-1:0]        line_total
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > lgb_pkg::COUNT_W) ? CW : lgb_pkg::COUNT_W;

  lgb_pkg::state_t  state, state_next;
  logic [CW-1:0]    gb, gb_next;
  logic [CW-1:0]    lag, lag_next;
  logic [CW-1:0]    target, target_next;
  logic             fetch, fetch_next;
  logic             move_left, move_left_next;
  logic [AW-1:0]    wr_addr, wr_addr_next;
  logic             res_valid_next;
  lgb_pkg::status_t status_q, status_next;
  logic [lgb_pkg::ENTRY_PORT_W-1:0] got, got_next;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  logic          accept;
  logic [CW-1:0] total;
  logic [CW-1:0] seek_target;
  logic          seek_bad;

  assign cmd_stall = (state != lgb_pkg::S_IDLE) || (res_valid && res_stall);
  assign accept    = cmd_valid && !cmd_stall;
  assign total     = CW'(gb + lag);
  assign seek_bad  = (total == '0) || (line_number == '0);
  // clamp a line past the end to the last line
  assign seek_target = (LW'(line_number) > LW'(total)) ? total : CW'(line_number);

  always_comb begin
    state_next     = state;
    gb_next        = gb;
    lag_next       = lag;
    target_next    = target;
    fetch_next     = fetch;
    move_left_next = move_left;
    wr_addr_next   = wr_addr;
    res_valid_next = res_valid && res_stall;
    status_next    = status_q;
    got_next       = got;
    ram_we         = 1'b0;
    ram_waddr      = gb[AW-1:0];
    ram_wdata      = ENTRY_WIDTH'(entry_value);
    ram_re         = 1'b0;
    ram_raddr      = AW'(target - 1'b1);
    case (state)
      lgb_pkg::S_IDLE: begin
        if (accept) begin
          status_next    = lgb_pkg::ST_OK;
          got_next       = '0;
          res_valid_next = 1'b1;
          case (lgb_pkg::mode_t'(mode))
            lgb_pkg::M_INSERT: begin
              if (total == CW'(DEPTH)) begin
                status_next = lgb_pkg::ST_FULL;
              end else begin
                ram_we  = 1'b1;
                gb_next = gb + 1'b1;
              end
            end
            lgb_pkg::M_DELETE: begin
              if (gb == '0) begin
                status_next = lgb_pkg::ST_START;
              end else begin
                gb_next = gb - 1'b1;
              end
            end
            lgb_pkg::M_LEFT: begin
              if (gb == '0) begin
                status_next = lgb_pkg::ST_START;
              end else begin
                target_next    = gb - 1'b1;
                fetch_next     = 1'b0;
                res_valid_next = 1'b0;
                state_next     = lgb_pkg::S_SWAP_RD;
              end
            end
            lgb_pkg::M_RIGHT: begin
              if (lag == '0) begin
                status_next = lgb_pkg::ST_END;
              end else begin
                target_next    = gb + 1'b1;
                fetch_next     = 1'b0;
                res_valid_next = 1'b0;
                state_next     = lgb_pkg::S_SWAP_RD;
              end
            end
            lgb_pkg::M_SEEK: begin
              if (seek_bad) begin
                status_next = lgb_pkg::ST_BAD;
              end else begin
                target_next    = seek_target;
                fetch_next     = 1'b1;
                res_valid_next = 1'b0;
                state_next     = lgb_pkg::S_SWAP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      lgb_pkg::S_SWAP_RD: begin
        if (gb == target) begin
          if (fetch) begin
            // wanted line now sits just before the gap
            ram_re     = 1'b1;
            ram_raddr  = AW'(target - 1'b1);
            state_next = lgb_pkg::S_FETCH;
          end else begin
            res_valid_next = 1'b1;
            state_next     = lgb_pkg::S_IDLE;
          end
        end else begin
          ram_re = 1'b1;
          if (gb > target) begin
            ram_raddr      = AW'(gb - 1'b1);
            wr_addr_next   = AW'(CW'(DEPTH - 1) - lag);
            move_left_next = 1'b1;
          end else begin
            ram_raddr      = AW'(CW'(DEPTH) - lag);
            wr_addr_next   = gb[AW-1:0];
            move_left_next = 1'b0;
          end
          state_next = lgb_pkg::S_SWAP_WR;
        end
      end
      lgb_pkg::S_SWAP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
        if (move_left) begin
          gb_next  = gb - 1'b1;
          lag_next = lag + 1'b1;
        end else begin
          gb_next  = gb + 1'b1;
          lag_next = lag - 1'b1;
        end
        state_next = lgb_pkg::S_SWAP_RD;
      end
      lgb_pkg::S_FETCH: begin
        got_next       = lgb_pkg::ENTRY_PORT_W'(ram_rdata);
        res_valid_next = 1'b1;
        state_next     = lgb_pkg::S_IDLE;
      end
      default: begin
        state_next = lgb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lgb_pkg::S_IDLE;
      gb        <= '0;
      lag       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gb        <= gb_next;
      lag       <= lag_next;
      res_valid <= res_valid_next;
    end
    target    <= target_next;
    fetch     <= fetch_next;
    move_left <= move_left_next;
    wr_addr   <= wr_addr_next;
    status_q  <= status_next;
    got       <= got_next;
  end

  lgb_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign status       = status_q;
  assign read_entry   = got;
  assign gap_position = lgb_pkg::COUNT_W'(gb);
  assign line_total   = lgb_pkg::COUNT_W'(total);

  `LGB_ASSERT_NOW(a_total_in_range, 1'b1, total <= CW'(DEPTH), "line count exceeds store depth")
  `LGB_ASSERT_NEXT(a_swap_keeps_total, state == lgb_pkg::S_SWAP_WR, total == $past(total), "gap swap changed the line count")
  `LGB_ASSERT_NEXT(a_held_result_stable, res_valid && res_stall, $stable(gb) && $stable(lag), "gap moved under a held result")
  `LGB_ASSERT_NOW(a_busy_no_result, state != lgb_pkg::S_IDLE, !res_valid, "result shown while a command is in progress")

endmodule

`default_nettype wire

[rtl/lgb_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module lgb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[test/lgb_checker.sv]
// watches both channels of the line gap buffer, predicts each result and compares
module lgb_checker #(
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  input  wire logic                             cmd_stall,
  input  wire logic [lgb_pkg::MODE_W-1:0]       mode,
  input  wire logic [lgb_pkg::ENTRY_PORT_W-1:0] entry_value,
  input  wire logic [lgb_pkg::COUNT_W-1:0]      line_number,
  input  wire logic                             res_valid,
  input  wire logic                             res_stall,
  input  wire logic [lgb_pkg::STATUS_W-1:0]     status,
  input  wire logic [lgb_pkg::ENTRY_PORT_W-1:0] read_entry,
  input  wire logic [lgb_pkg::COUNT_W-1:0]      gap_position,
  input  wire logic [lgb_pkg::COUNT_W-1:0]      line_total,
  output int                                    failures,
  output int                                    outstanding
);

  typedef struct packed {
    lgb_pkg::status_t                 st;
    logic [lgb_pkg::ENTRY_PORT_W-1:0] entry;
    logic [lgb_pkg::COUNT_W-1:0]      gap;
    logic [lgb_pkg::COUNT_W-1:0]      total;
  } edit_result_t;

  // shadow copy of the document
  logic [lgb_pkg::ENTRY_PORT_W-1:0] doc_lines [0:DEPTH-1];
  int unsigned                      before_gap = 0;
  int unsigned                      after_gap = 0;
  edit_result_t                     pending_results [$];
  int                               mismatches = 0;

  function automatic void shift_gap_left();
    doc_lines[DEPTH-1-after_gap] = doc_lines[before_gap-1];
    before_gap--;
    after_gap++;
  endfunction

  function automatic void shift_gap_right();
    doc_lines[before_gap] = doc_lines[DEPTH-after_gap];
    before_gap++;
    after_gap--;
  endfunction

  function automatic edit_result_t edit_document(
    input logic [lgb_pkg::MODE_W-1:0]       m,
    input logic [lgb_pkg::ENTRY_PORT_W-1:0] v,
    input logic [lgb_pkg::COUNT_W-1:0]      n
  );
    edit_result_t r;
    int unsigned  in_use;
    int unsigned  target;
    r.st    = lgb_pkg::ST_OK;
    r.entry = '0;
    in_use  = before_gap + after_gap;
    case (m)
      lgb_pkg::M_INSERT: begin
        if (in_use >= DEPTH) begin
          r.st = lgb_pkg::ST_FULL;
        end else begin
          doc_lines[before_gap] = v;
          before_gap++;
        end
      end
      lgb_pkg::M_DELETE: begin
        if (before_gap == 0) r.st = lgb_pkg::ST_START;
        else before_gap--;
      end
      lgb_pkg::M_LEFT: begin
        if (before_gap == 0) r.st = lgb_pkg::ST_START;
        else shift_gap_left();
      end
      lgb_pkg::M_RIGHT: begin
        if (after_gap == 0) r.st = lgb_pkg::ST_END;
        else shift_gap_right();
      end
      lgb_pkg::M_SEEK: begin
        if (in_use == 0 || n == 0) begin
          r.st = lgb_pkg::ST_BAD;
        end else begin
          // a line past the end lands on the last line
          target = (32'(n) > in_use) ? in_use : 32'(n);
          while (before_gap > target) shift_gap_left();
          while (before_gap < target) shift_gap_right();
          r.entry = doc_lines[target-1];
        end
      end
      default: ;
    endcase
    r.gap   = before_gap[lgb_pkg::COUNT_W-1:0];
    r.total = lgb_pkg::COUNT_W'(before_gap + after_gap);
    return r;
  endfunction

  task automatic check_field(input string name,
                             input logic [lgb_pkg::ENTRY_PORT_W-1:0] want,
                             input logic [lgb_pkg::ENTRY_PORT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    edit_result_t want;
    if (rst) begin
      before_gap = 0;
      after_gap  = 0;
      pending_results.delete();
    end else begin
      // retire first: a result never belongs to a transaction taken on the same edge
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", lgb_pkg::ENTRY_PORT_W'(want.st),
                      lgb_pkg::ENTRY_PORT_W'(status));
          check_field("read_entry", want.entry, read_entry);
          check_field("gap_position", lgb_pkg::ENTRY_PORT_W'(want.gap),
                      lgb_pkg::ENTRY_PORT_W'(gap_position));
          check_field("line_total", lgb_pkg::ENTRY_PORT_W'(want.total),
                      lgb_pkg::ENTRY_PORT_W'(line_total));
        end
      end
      if (cmd_valid && !cmd_stall)
        pending_results.push_back(edit_document(mode, entry_value, line_number));
    end
    failures    <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

[test/testbench.sv]
// stimulus and verdict for the line gap buffer
module testbench;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int BLOCK_ITEMS = 240;
  localparam logic [lgb_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [lgb_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef enum int {MIX_EVEN, MIX_FILL, MIX_DRAIN} edit_mix_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cmd_valid = 1'b0;
  logic                             cmd_stall;
  logic [lgb_pkg::MODE_W-1:0]       mode = lgb_pkg::M_INSERT;
  logic [lgb_pkg::ENTRY_PORT_W-1:0] entry_value = '0;
  logic [lgb_pkg::COUNT_W-1:0]      line_number = '0;
  logic                             res_valid;
  logic                             res_stall = 1'b0;
  logic [lgb_pkg::STATUS_W-1:0]     status;
  logic [lgb_pkg::ENTRY_PORT_W-1:0] read_entry;
  logic [lgb_pkg::COUNT_W-1:0]      gap_position;
  logic [lgb_pkg::COUNT_W-1:0]      line_total;
  int                               failures;
  int                               outstanding;
  int                               idle_pct = 0;
  int                               stall_pct = 0;
  int                               cycles = 0;
  edit_mix_t                        block_mix [0:7];

  line_gap_buffer uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .mode(mode), .entry_value(entry_value), .line_number(line_number),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .read_entry(read_entry),
    .gap_position(gap_position), .line_total(line_total)
  );

  lgb_checker checker_i (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .mode(mode), .entry_value(entry_value), .line_number(line_number),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .read_entry(read_entry),
    .gap_position(gap_position), .line_total(line_total),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** line_gap_buffer: FAILED **");
      $finish;
    end
  end

  task automatic issue_command(input logic [lgb_pkg::MODE_W-1:0] m,
                               input logic [lgb_pkg::ENTRY_PORT_W-1:0] v,
                               input logic [lgb_pkg::COUNT_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    mode        <= m;
    entry_value <= v;
    line_number <= n;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic wait_settled();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_command(input edit_mix_t mix);
    int                               roll;
    int                               pick;
    logic [lgb_pkg::MODE_W-1:0]       m;
    logic [lgb_pkg::ENTRY_PORT_W-1:0] v;
    logic [lgb_pkg::COUNT_W-1:0]      n;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:
        m = roll < 70 ? lgb_pkg::M_INSERT : roll < 76 ? lgb_pkg::M_DELETE :
            roll < 84 ? lgb_pkg::M_LEFT : roll < 92 ? lgb_pkg::M_RIGHT :
            lgb_pkg::M_SEEK;
      MIX_DRAIN:
        m = roll < 55 ? lgb_pkg::M_DELETE : roll < 60 ? lgb_pkg::M_LEFT :
            roll < 80 ? lgb_pkg::M_RIGHT : roll < 88 ? lgb_pkg::M_INSERT :
            lgb_pkg::M_SEEK;
      default:
        m = roll < 30 ? lgb_pkg::M_INSERT : roll < 45 ? lgb_pkg::M_DELETE :
            roll < 60 ? lgb_pkg::M_LEFT : roll < 75 ? lgb_pkg::M_RIGHT :
            roll < 99 ? lgb_pkg::M_SEEK : lgb_pkg::MODE_W'($urandom_range(5, 7));
    endcase
    pick = $urandom_range(15);
    v = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
    pick = $urandom_range(9);
    if (pick == 0) n = '0;
    else if (pick == 1) n = 9'd256;
    else if (pick < 6) n = lgb_pkg::COUNT_W'($urandom_range(1, 16));
    else n = lgb_pkg::COUNT_W'($urandom_range(1, 256));
    issue_command(m, v, n);
  endtask

  initial begin
    block_mix = '{MIX_EVEN, MIX_FILL, MIX_FILL, MIX_DRAIN,
                  MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_EVEN};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty document, bounds and spare modes
    issue_command(lgb_pkg::M_SEEK, '0, 9'd1);
    issue_command(lgb_pkg::M_DELETE, '0, '0);
    issue_command(lgb_pkg::M_LEFT, '0, '0);
    issue_command(lgb_pkg::M_RIGHT, '0, '0);
    issue_command(MODE_SPARE_HI, '1, '1);
    issue_command(lgb_pkg::M_INSERT, '0, '0);
    issue_command(lgb_pkg::M_INSERT, '1, '0);
    issue_command(lgb_pkg::M_INSERT, 32'hA5A5_5A5A, '0);
    issue_command(lgb_pkg::M_INSERT, 32'h5A5A_A5A5, '0);
    issue_command(lgb_pkg::M_SEEK, '0, '0);
    issue_command(lgb_pkg::M_SEEK, '0, 9'd256);
    issue_command(lgb_pkg::M_SEEK, '0, 9'd1);
    issue_command(lgb_pkg::M_LEFT, '0, '0);
    issue_command(lgb_pkg::M_LEFT, '0, '0);
    issue_command(lgb_pkg::M_RIGHT, '0, '0);
    issue_command(lgb_pkg::M_RIGHT, '0, '0);
    issue_command(lgb_pkg::M_SEEK, '0, 9'd2);
    issue_command(lgb_pkg::M_DELETE, '0, '0);
    issue_command(MODE_SPARE_LO, 32'h1234_5678, 9'd3);
    issue_command(lgb_pkg::M_SEEK, '0, 9'd3);
    issue_command(lgb_pkg::M_DELETE, '0, '0);
    issue_command(lgb_pkg::M_RIGHT, '0, '0);
    wait_settled();

    for (int b = 0; b < 8; b++) begin
      case (b % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int i = 0; i < BLOCK_ITEMS; i++) random_command(block_mix[b]);
      // hold off until the buffer has answered everything
      wait_settled();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("** line_gap_buffer: PASSED **");
    end else begin
      $display("** line_gap_buffer: FAILED **");
    end
    $finish;
  end

endmodule
